// ===== rtl/sus_pkg.sv =====
// Shared types and constants for the sorted unique key set.
`timescale 1ns / 1ps

package sus_pkg;

    // Default geometry of the store
    localparam int SUS_DEPTH     = 64;
    localparam int SUS_KEY_WIDTH = 32;

    // Fixed widths of the result fields
    localparam int COUNT_OUT_W = 7;
    localparam int POS_OUT_W   = 6;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_REPLACE = 2'd2,
        OP_SEARCH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_INS_NEW
    } state_t;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_cmd_t;

    // Match flags gathered over the whole row
    typedef struct packed {
        logic hit_a;
        logic hit_b;
    } rank_flags_t;

endpackage

// ===== rtl/sus_cell.sv =====
// One storage cell of the key row: compare against probes, shift left or right.
`timescale 1ns / 1ps

module sus_cell import sus_pkg::*; #(
    parameter int KEY_WIDTH = SUS_KEY_WIDTH
) (
    input  logic                        clk,
    input  logic                        occ,
    input  cell_cmd_t                   cmd,
    input  logic signed [KEY_WIDTH-1:0] probe_a,
    input  logic signed [KEY_WIDTH-1:0] probe_b,
    input  logic                        left_lt,
    input  logic signed [KEY_WIDTH-1:0] left_key,
    input  logic signed [KEY_WIDTH-1:0] right_key,
    output logic signed [KEY_WIDTH-1:0] key_q,
    output logic                        lt_a,
    output logic                        eq_a,
    output logic                        eq_b
);

    logic signed [KEY_WIDTH-1:0] key_reg;
    logic signed [KEY_WIDTH-1:0] key_next;

    assign key_q = key_reg;
    assign lt_a  = occ && (key_reg < probe_a);
    assign eq_a  = occ && (key_reg == probe_a);
    assign eq_b  = occ && (key_reg == probe_b);

    // Cells below the probe hold; the rest open a gap or close one
    always_comb
    begin
        key_next = key_reg;
        if (cmd.insert && !lt_a)
        begin
            key_next = left_lt ? probe_a : left_key;
        end
        else if (cmd.remove && !lt_a)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== rtl/sus_rank.sv =====
// Turns the row's compare flags into a sorted position and match flags.
`timescale 1ns / 1ps

module sus_rank import sus_pkg::*; #(
    parameter int DEPTH = SUS_DEPTH,
    localparam int POS_W = $clog2(DEPTH + 1)
) (
    input  logic [DEPTH-1:0] lt_vec,
    input  logic [DEPTH-1:0] eq_a_vec,
    input  logic [DEPTH-1:0] eq_b_vec,
    output logic [POS_W-1:0] pos,
    output rank_flags_t      flags
);

    logic [DEPTH:0] bnd;

    // lt_vec is a run of ones from cell 0; mark the first cell past the run
    always_comb
    begin
        bnd[0]     = !lt_vec[0];
        bnd[DEPTH] = lt_vec[DEPTH-1];
        for (int i = 1; i < DEPTH; i++)
        begin
            bnd[i] = lt_vec[i-1] && !lt_vec[i];
        end
    end

    always_comb
    begin
        pos = '0;
        for (int i = 0; i <= DEPTH; i++)
        begin
            if (bnd[i])
            begin
                pos = pos | POS_W'(i);
            end
        end
    end

    assign flags.hit_a = |eq_a_vec;
    assign flags.hit_b = |eq_b_vec;

endmodule

// ===== rtl/sorted_unique_set.sv =====
// Sorted unique key set: a row of compare-and-shift cells under a small sequencer.
//
// Requests arrive on the in_ channel (op, key, new_key) with valid/ready; one
// result per request leaves on the out_ channel (status, entry_count, position)
// with valid/ready. in_ready is high while no request is being worked on.
// A request is taken at the edge where in_valid and in_ready are both high; the
// next cycle every cell compares its key with the request key at once. Once the
// output register is free, the row shifts to open or close a gap where the
// request needs one and the result is registered at that same edge. A replace
// does a remove pass then an insert pass of new_key through the same row. The
// output register frees the input side: a new request is taken while the
// previous result still waits. If a result is still held when the next one is
// ready, the sequencer holds that request (and the row) until the receiver
// takes the old result.
// Reset empties the set (entry count zero) and drops any pending result; cell
// contents are left as they are and never read while unoccupied.
`timescale 1ns / 1ps

module sorted_unique_set import sus_pkg::*; #(
    parameter int DEPTH     = SUS_DEPTH,
    parameter int KEY_WIDTH = SUS_KEY_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  op,
    input  logic signed [KEY_WIDTH-1:0] key,
    input  logic signed [KEY_WIDTH-1:0] new_key,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [COUNT_OUT_W-1:0]      entry_count,
    output logic [POS_OUT_W-1:0]        position
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Sequencer and request registers
    state_t                      state_reg, state_next;
    op_t                         op_reg;
    logic signed [KEY_WIDTH-1:0] key_reg;
    logic signed [KEY_WIDTH-1:0] nk_reg;
    logic [CNT_W-1:0]            count_reg, count_next;

    // Result register
    logic                        out_valid_reg;
    status_t                     status_reg, status_next;
    logic [CNT_W-1:0]            res_count_reg;
    logic [CNT_W-1:0]            res_pos_reg, res_pos_next;

    logic                        emit;
    logic                        out_free;
    cell_cmd_t                   cmd;

    // Cell row
    logic signed [KEY_WIDTH-1:0] probe_a;
    logic signed [KEY_WIDTH-1:0] cell_key [DEPTH];
    logic [DEPTH-1:0]            lt_vec;
    logic [DEPTH-1:0]            eq_a_vec;
    logic [DEPTH-1:0]            eq_b_vec;
    logic [CNT_W-1:0]            rank_pos;
    rank_flags_t                 flags;
    logic                        full;

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));

    // Second pass of a replace probes with the new key
    assign probe_a = (state_reg == S_INS_NEW) ? nk_reg : key_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                        occ;
        logic                        left_lt;
        logic signed [KEY_WIDTH-1:0] left_key;
        logic signed [KEY_WIDTH-1:0] right_key;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_lt  = 1'b1;
            assign left_key = probe_a;
        end
        else
        begin : g_mid
            assign left_lt  = lt_vec[i-1];
            assign left_key = cell_key[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_key = cell_key[i];
        end
        else
        begin : g_inner
            assign right_key = cell_key[i+1];
        end

        sus_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .clk       (clk),
            .occ       (occ),
            .cmd       (cmd),
            .probe_a   (probe_a),
            .probe_b   (nk_reg),
            .left_lt   (left_lt),
            .left_key  (left_key),
            .right_key (right_key),
            .key_q     (cell_key[i]),
            .lt_a      (lt_vec[i]),
            .eq_a      (eq_a_vec[i]),
            .eq_b      (eq_b_vec[i])
        );
    end

    sus_rank #(
        .DEPTH (DEPTH)
    ) u_rank (
        .lt_vec   (lt_vec),
        .eq_a_vec (eq_a_vec),
        .eq_b_vec (eq_b_vec),
        .pos      (rank_pos),
        .flags    (flags)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_REPLACE && flags.hit_a && !flags.hit_b)
                begin
                    state_next = S_INS_NEW;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_INS_NEW:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Row commands, count update and result
    always_comb
    begin
        cmd          = '0;
        emit         = 1'b0;
        status_next  = ST_OK;
        res_pos_next = '0;
        count_next   = count_reg;
        unique case (state_reg)
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        emit = out_free;
                        if (flags.hit_a)
                        begin
                            status_next = ST_PRESENT;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.insert   = out_free;
                            res_pos_next = rank_pos;
                            count_next   = out_free ? count_reg + 1'b1 : count_reg;
                        end
                    end
                    OP_REMOVE:
                    begin
                        emit = out_free;
                        if (!flags.hit_a)
                        begin
                            status_next = ST_ABSENT;
                        end
                        else
                        begin
                            cmd.remove   = out_free;
                            res_pos_next = rank_pos;
                            count_next   = out_free ? count_reg - 1'b1 : count_reg;
                        end
                    end
                    OP_REPLACE:
                    begin
                        if (!flags.hit_a)
                        begin
                            emit        = out_free;
                            status_next = ST_ABSENT;
                        end
                        else if (flags.hit_b)
                        begin
                            emit        = out_free;
                            status_next = ST_PRESENT;
                        end
                        else
                        begin
                            // Take out the old key; the new key goes in on the S_INS_NEW pass
                            cmd.remove = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    OP_SEARCH:
                    begin
                        emit = out_free;
                        if (!flags.hit_a)
                        begin
                            status_next = ST_ABSENT;
                        end
                        else
                        begin
                            res_pos_next = rank_pos;
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
            S_INS_NEW:
            begin
                emit         = out_free;
                cmd.insert   = out_free;
                res_pos_next = rank_pos;
                count_next   = out_free ? count_reg + 1'b1 : count_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= op_t'(op);
            key_reg <= key;
            nk_reg  <= new_key;
        end
        if (emit)
        begin
            status_reg    <= status_next;
            res_count_reg <= count_next;
            res_pos_reg   <= res_pos_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = COUNT_OUT_W'(res_count_reg);
    assign position    = POS_OUT_W'(res_pos_reg);

    // The store never holds more keys than cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // Held keys stay ascending: cells below the probe form one run from cell 0
    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        ((lt_vec + 1'b1) & lt_vec) == '0)
        else $error("cell row out of order");

    // Every insert shift adds exactly one key
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the count");

endmodule

// ===== bench/tb_sorted_unique_set.sv =====
// Self-checking testbench for the sorted unique key set.
`timescale 1ns / 1ps

module tb_sorted_unique_set;
    import sus_pkg::*;

    localparam int KW         = SUS_KEY_WIDTH;
    localparam int CAP        = SUS_DEPTH;
    localparam int IDLE_PCT   = 27;
    localparam int HOLD_LEN   = 60;      // long receiver hold-off, in cycles
    localparam int DRAIN_WAIT = 8;       // replace is the slowest request
    localparam int LIMIT      = 200000;  // far above the slowest legal run

    localparam logic signed [KW-1:0] KEY_MIN = {1'b1, {(KW-1){1'b0}}};
    localparam logic signed [KW-1:0] KEY_MAX = {1'b0, {(KW-1){1'b1}}};

    // One result as the block reports it
    typedef struct packed {
        status_t                st;
        logic [COUNT_OUT_W-1:0] cnt;
        logic [POS_OUT_W-1:0]   pos;
    } set_result_t;

    // One row of the directed table; fixed = 1 means the result is typed in
    typedef struct packed {
        op_t                    op;
        logic [KW-1:0]          k;
        logic [KW-1:0]          nk;
        logic                   fixed;
        status_t                st;
        logic [COUNT_OUT_W-1:0] cnt;
        logic [POS_OUT_W-1:0]   pos;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [1:0]                  op;
    logic signed [KW-1:0]        key;
    logic signed [KW-1:0]        new_key;
    logic                        out_valid;
    logic                        out_ready;
    logic [1:0]                  status;
    logic [COUNT_OUT_W-1:0]      entry_count;
    logic [POS_OUT_W-1:0]        position;

    // Typed-in expectation travelling alongside the request payload
    logic                        drv_fixed;
    status_t                     drv_st;
    logic [COUNT_OUT_W-1:0]      drv_cnt;
    logic [POS_OUT_W-1:0]        drv_pos;

    // Shadow copy of the set, kept in ascending key order
    logic signed [KW-1:0]        held_keys [CAP];
    int                          held_count;

    set_result_t                 pending_results [$];
    stim_row_t                   directed_rows [$];

    int                          fault_count;
    int                          cycle_count;
    bit                          quiet;       // no idling on either side
    bit                          hold_start;  // asks the receiver for its long hold-off

    sorted_unique_set dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .key         (key),
        .new_key     (new_key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count),
        .position    (position)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Number of held keys strictly below k; present tells whether k is held
    function automatic int key_rank(input logic signed [KW-1:0] k, output bit present);
        int i;
        i = 0;
        present = 1'b0;
        while (i < held_count && held_keys[i] < k)
            i++;
        if (i < held_count && held_keys[i] == k)
            present = 1'b1;
        return i;
    endfunction

    function automatic void close_gap(input int at);
        for (int i = at; i + 1 < held_count; i++)
            held_keys[i] = held_keys[i + 1];
        held_count--;
    endfunction

    function automatic void open_gap(input int at, input logic signed [KW-1:0] k);
        for (int i = held_count; i > at; i--)
            held_keys[i] = held_keys[i - 1];
        held_keys[at] = k;
        held_count++;
    endfunction

    // Applies one request to the shadow set and gives the result it must produce
    function automatic set_result_t apply_request(input op_t o,
                                                  input logic signed [KW-1:0] k,
                                                  input logic signed [KW-1:0] nk);
        set_result_t r;
        bit          hit;
        bit          hit_new;
        int          p;
        int          q;
        r.st = ST_OK;
        r.pos = '0;
        p = key_rank(k, hit);
        case (o)
            OP_INSERT:
            begin
                // a present key wins over a full store
                if (hit)
                    r.st = ST_PRESENT;
                else if (held_count >= CAP)
                    r.st = ST_FULL;
                else
                begin
                    open_gap(p, k);
                    r.pos = POS_OUT_W'(p);
                end
            end
            OP_REMOVE:
            begin
                if (!hit)
                    r.st = ST_ABSENT;
                else
                begin
                    close_gap(p);
                    r.pos = POS_OUT_W'(p);
                end
            end
            OP_REPLACE:
            begin
                // absent old key wins; new key equal to old counts as present
                if (!hit)
                    r.st = ST_ABSENT;
                else
                begin
                    void'(key_rank(nk, hit_new));
                    if (hit_new)
                        r.st = ST_PRESENT;
                    else
                    begin
                        close_gap(p);
                        q = key_rank(nk, hit_new);
                        open_gap(q, nk);
                        r.pos = POS_OUT_W'(q);
                    end
                end
            end
            default:
            begin
                if (!hit)
                    r.st = ST_ABSENT;
                else
                    r.pos = POS_OUT_W'(p);
            end
        endcase
        r.cnt = COUNT_OUT_W'(held_count);
        return r;
    endfunction

    function automatic void add_row(input op_t o, input logic [KW-1:0] k,
                                    input logic [KW-1:0] nk, input bit fixed,
                                    input status_t s, input int c, input int p);
        directed_rows.push_back('{o, k, nk, fixed, s, COUNT_OUT_W'(c), POS_OUT_W'(p)});
    endfunction

    // Mostly a small pool so keys collide, some extremes, some full-range values
    function automatic logic signed [KW-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return KW'($signed($urandom_range(0, 80)) - 40);
        if (r < 72)
        begin
            case ($urandom_range(0, 5))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return KEY_MIN + 1;
                3: return KEY_MAX - 1;
                4: return '0;
                default: return '1;
            endcase
        end
        return KW'($urandom);
    endfunction

    function automatic op_t pick_op(input int phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            0: return (r < 85) ? OP_INSERT : op_t'($urandom_range(0, 3));
            2: return (r < 70) ? OP_REMOVE : op_t'($urandom_range(0, 3));
            default: return op_t'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic void report_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", what);
    endfunction

    // Offers one request and returns at the edge where it is taken
    task automatic send_request(input op_t o, input logic signed [KW-1:0] k,
                                input logic signed [KW-1:0] nk, input bit fixed,
                                input status_t s, input logic [COUNT_OUT_W-1:0] c,
                                input logic [POS_OUT_W-1:0] p);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        key       <= k;
        new_key   <= nk;
        drv_fixed <= fixed;
        drv_st    <= s;
        drv_cnt   <= c;
        drv_pos   <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Receiver: random back-pressure, plus one long hold-off so the block
    // fills up and stalls its input side
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_start)
            begin
                out_ready  <= 1'b0;
                hold_left  = HOLD_LEN - 1;
                hold_start = 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: predict on every accepted request, check every accepted result.
    // All values are sampled at the edge, before any driver update lands.
    always @(posedge clk)
    begin
        set_result_t predicted;
        set_result_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predicted = apply_request(op_t'(op), key, new_key);
                if (drv_fixed)
                    predicted = '{drv_st, drv_cnt, drv_pos};
                pending_results.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                got = '{status_t'(status), entry_count, position};
                if (pending_results.size() == 0)
                    report_fault($sformatf("unexpected result: status %0d count %0d pos %0d",
                                           status, entry_count, position));
                else
                begin
                    predicted = pending_results.pop_front();
                    if (got.st !== predicted.st || got.cnt !== predicted.cnt ||
                        got.pos !== predicted.pos)
                        report_fault($sformatf(
                            "mismatch: expected status %0d count %0d pos %0d, got %0d %0d %0d",
                            predicted.st, predicted.cnt, predicted.pos,
                            status, entry_count, position));
                end
            end
        end
    end

    // Run limit
    initial
    begin
        @(posedge clk);
        while (cycle_count < LIMIT)
            @(posedge clk);
        $display("sorted_unique_set test failed");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        op_t                  o;
        logic signed [KW-1:0] k;
        logic signed [KW-1:0] nk;
        int                   phase_len [4];

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_INSERT;
        key         = '0;
        new_key     = '0;
        out_ready   = 1'b0;
        drv_fixed   = 1'b0;
        drv_st      = ST_OK;
        drv_cnt     = '0;
        drv_pos     = '0;
        held_count  = 0;
        fault_count = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        hold_start  = 1'b0;
        for (int i = 0; i < CAP; i++)
            held_keys[i] = '0;

        // Empty store: every lookup misses
        add_row(OP_SEARCH,  0,       0,       1, ST_ABSENT,  0, 0);
        add_row(OP_REMOVE,  5,       0,       1, ST_ABSENT,  0, 0);
        add_row(OP_REPLACE, 1,       2,       1, ST_ABSENT,  0, 0);
        // Extremes go to the ends of the order
        add_row(OP_INSERT,  0,       0,       1, ST_OK,      1, 0);
        add_row(OP_INSERT,  KEY_MIN, 0,       1, ST_OK,      2, 0);
        add_row(OP_INSERT,  KEY_MAX, 0,       1, ST_OK,      3, 2);
        add_row(OP_INSERT,  0,       0,       1, ST_PRESENT, 3, 0);
        add_row(OP_SEARCH,  KEY_MAX, 0,       1, ST_OK,      3, 2);
        add_row(OP_SEARCH,  -1,      0,       1, ST_ABSENT,  3, 0);
        // Replace onto a held key, onto itself, and from an absent key
        add_row(OP_REPLACE, 0,       KEY_MAX, 1, ST_PRESENT, 3, 0);
        add_row(OP_REPLACE, 0,       0,       1, ST_PRESENT, 3, 0);
        add_row(OP_REPLACE, -7,      KEY_MIN, 1, ST_ABSENT,  3, 0);
        add_row(OP_REPLACE, KEY_MIN, 5,       0, ST_OK,      0, 0);
        add_row(OP_INSERT,  -1,      0,       0, ST_OK,      0, 0);
        add_row(OP_REMOVE,  KEY_MAX, 0,       0, ST_OK,      0, 0);
        add_row(OP_SEARCH,  5,       0,       0, ST_OK,      0, 0);
        add_row(OP_REMOVE,  KEY_MIN, 0,       0, ST_OK,      0, 0);
        add_row(OP_REPLACE, -1,      KEY_MIN, 0, ST_OK,      0, 0);
        add_row(OP_REMOVE,  0,       0,       0, ST_OK,      0, 0);
        add_row(OP_INSERT,  KEY_MAX - 1, 0,   0, ST_OK,      0, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].k, directed_rows[i].nk,
                         directed_rows[i].fixed, directed_rows[i].st,
                         directed_rows[i].cnt, directed_rows[i].pos);

        // Fill to full, churn, drain, churn again
        phase_len = '{200, 180, 150, 120};
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int n = 0; n < phase_len[ph]; n++)
            begin
                if (ph == 0 && n == 40)
                    hold_start = 1'b1;
                quiet = (ph == 1 && n < 120);
                o  = pick_op(ph);
                k  = pick_key();
                nk = ($urandom_range(0, 99) < 15) ? k : pick_key();
                send_request(o, k, nk, 1'b0, ST_OK, '0, '0);
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fault_count == 0 && pending_results.size() == 0)
            $display("sorted_unique_set test passed");
        else
            $display("sorted_unique_set test failed");
        $finish;
    end

endmodule
